// ===== sv/wbps_pkg.sv =====
// Shared types and codes for the wildcard byte pattern scanner.
// Used by wbps_parser and wildcard_byte_pattern_scanner_unit.
package wbps_pkg;

    localparam logic [1:0] MODE_TEXT  = 2'd0;
    localparam logic [1:0] MODE_DATA  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] value;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic        found;
        logic [31:0] offset;
        logic        overflow;
    } t_out_beat;

    typedef struct packed {
        logic       push;
        logic [7:0] pat_byte;
        logic       wild;
    } t_append;

endpackage

// ===== sv/wildcard_byte_pattern_scanner_unit.sv =====
// Top level of the wildcard byte pattern scanner: text decoder, cell row, result buffer.
// Depends on wbps_pkg, wbps_parser and wbps_cell.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one beat per item:
//   mode 0 is a pattern text character, mode 1 a data byte, mode 2 clears the
//   pattern and the scan. Mode 3 is ignored.
//   Pattern cell k holds the k-th newest pattern byte and window cell k the
//   k-th newest data byte, so every cell compares in place as a byte arrives.
//   Output channel (o_out_valid / i_out_ready / o_out_data) carries at most one
//   result per data byte: found with the match start offset, or not found on the
//   last byte of a scan, plus the pattern overflow flag.
//   Throughput: one item per cycle while o_in_ready is high; the match test over all
//   cells settles in the cycle the byte is taken, and its result is then registered.
//   A two-entry result buffer decouples the sides; o_in_ready drops only while
//   both entries are held by a stalled receiver.
//   Reset empties the pattern, the scan window and the result buffer at once.
module wildcard_byte_pattern_scanner_unit #(
    parameter int PATTERN_MAX = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  wbps_pkg::t_in_beat    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output wbps_pkg::t_out_beat   o_out_data
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic                   w_acc;
    logic                   w_text;
    logic                   w_data;
    logic                   w_clear;
    wbps_pkg::t_append      w_append;
    logic                   w_shift_pat;
    logic                   w_shift_win;
    logic                   w_clr_win;
    logic                   w_match;
    logic                   w_has_res;
    wbps_pkg::t_out_beat    w_res;

    logic [LEN_W-1:0]       r_len;
    logic                   r_ovf;
    logic [31:0]            r_seen;
    logic                   r_done;

    logic [7:0]             w_pat   [PATTERN_MAX];
    logic                   w_wild  [PATTERN_MAX];
    logic [7:0]             w_win   [PATTERN_MAX];
    logic                   w_win_v [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] w_hit;

    wbps_pkg::t_out_beat    r_main;
    logic                   r_main_v;
    wbps_pkg::t_out_beat    r_skid;
    logic                   r_skid_v;
    logic                   w_pop;

    assign o_in_ready = !r_skid_v;
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        w_text  = 1'b0;
        w_data  = 1'b0;
        w_clear = 1'b0;
        unique case (i_in_data.mode)
            wbps_pkg::MODE_TEXT:  w_text  = w_acc;
            wbps_pkg::MODE_DATA:  w_data  = w_acc;
            wbps_pkg::MODE_CLEAR: w_clear = w_acc;
            default: ;
        endcase
    end

    wbps_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_text),
        .i_flush  (w_clear || w_data),
        .i_char   (i_in_data.value),
        .o_append (w_append)
    );

    assign w_shift_pat = w_append.push && (r_len < LEN_W'(PATTERN_MAX));
    assign w_shift_win = w_data && !r_done;
    assign w_clr_win   = w_clear || (w_data && i_in_data.last);

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        logic [7:0] w_pat_in;
        logic       w_wild_in;
        logic [7:0] w_win_in;
        logic       w_win_v_in;

        if (k == 0) begin : g_head
            assign w_pat_in   = w_append.pat_byte;
            assign w_wild_in  = w_append.wild;
            assign w_win_in   = i_in_data.value;
            assign w_win_v_in = 1'b1;
        end else begin : g_body
            assign w_pat_in   = w_pat[k-1];
            assign w_wild_in  = w_wild[k-1];
            assign w_win_in   = w_win[k-1];
            assign w_win_v_in = w_win_v[k-1];
        end

        wbps_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_shift_pat (w_shift_pat),
            .i_pat       (w_pat_in),
            .i_wild      (w_wild_in),
            .o_pat       (w_pat[k]),
            .o_wild      (w_wild[k]),
            .i_shift_win (w_shift_win),
            .i_clr_win   (w_clr_win),
            .i_win       (w_win_in),
            .i_win_v     (w_win_v_in),
            .o_win       (w_win[k]),
            .o_win_v     (w_win_v[k]),
            .i_active    (LEN_W'(k) < r_len),
            .o_hit       (w_hit[k])
        );
    end

    assign w_match   = &w_hit;
    assign w_has_res = w_shift_win && (w_match || i_in_data.last);

    always_comb begin
        w_res          = '0;
        w_res.overflow = r_ovf;
        if (w_match) begin
            w_res.found = 1'b1;
            if (r_len == '0) begin
                w_res.offset = r_seen;
            end else begin
                w_res.offset = r_seen + 32'd1 - 32'(r_len);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_ovf  <= 1'b0;
            r_seen <= 32'd0;
            r_done <= 1'b0;
        end else begin
            if (w_clear) begin
                r_len <= '0;
                r_ovf <= 1'b0;
            end else if (w_shift_pat) begin
                r_len <= r_len + LEN_W'(1);
            end else if (w_append.push) begin
                r_ovf <= 1'b1;
            end
            if (w_clr_win) begin
                r_seen <= 32'd0;
                r_done <= 1'b0;
            end else if (w_shift_win) begin
                r_seen <= r_seen + 32'd1;
                if (w_match) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign w_pop = r_main_v && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_pop) begin
                r_main   <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (w_has_res) begin
            if (!r_main_v || w_pop) begin
                r_main   <= w_res;
                r_main_v <= 1'b1;
            end else begin
                r_skid   <= w_res;
                r_skid_v <= 1'b1;
            end
        end else if (w_pop) begin
            r_main_v <= 1'b0;
        end
    end

    assign o_out_valid = r_main_v;
    assign o_out_data  = r_main;

endmodule

// ===== sv/wbps_parser.sv =====
// Pattern text decoder: turns hex text, spaces and '?' into pattern bytes.
// Depends on wbps_pkg for the append request type.
module wbps_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic                i_flush,
    input  logic [7:0]          i_char,
    output wbps_pkg::t_append   o_append
);

    localparam logic [7:0] CHAR_QUESTION = 8'h3F;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;

    logic [3:0] r_high;
    logic [3:0] n_high;
    logic       r_pending;
    logic       n_pending;
    logic       r_after_q;
    logic       n_after_q;
    logic [3:0] w_hex;

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h37);
        end
        return v;
    endfunction

    assign w_hex = hex_val(i_char);

    always_comb begin
        n_high    = r_high;
        n_pending = r_pending;
        n_after_q = r_after_q;
        o_append  = '0;
        priority if (i_flush) begin
            n_high    = 4'd0;
            n_pending = 1'b0;
            n_after_q = 1'b0;
        end else if (i_take) begin
            priority if (r_pending) begin
                o_append.push     = 1'b1;
                o_append.pat_byte = {r_high, w_hex};
                n_pending         = 1'b0;
                n_after_q         = 1'b0;
            end else if (r_after_q && i_char == CHAR_QUESTION) begin
                n_after_q = 1'b0;
            end else if (i_char == CHAR_SPACE) begin
                n_after_q = 1'b0;
            end else if (i_char == CHAR_QUESTION) begin
                o_append.push = 1'b1;
                o_append.wild = 1'b1;
                n_after_q     = 1'b1;
            end else begin
                n_high    = w_hex;
                n_pending = 1'b1;
                n_after_q = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high    <= 4'd0;
            r_pending <= 1'b0;
            r_after_q <= 1'b0;
        end else begin
            r_high    <= n_high;
            r_pending <= n_pending;
            r_after_q <= n_after_q;
        end
    end

endmodule

// ===== sv/wbps_cell.sv =====
// One scan cell: holds a pattern byte with its wildcard mark and one window byte.
// Both shift to the next cell; the cell flags a hit against the incoming byte.
module wbps_cell (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift_pat,
    input  logic [7:0] i_pat,
    input  logic       i_wild,
    output logic [7:0] o_pat,
    output logic       o_wild,
    input  logic       i_shift_win,
    input  logic       i_clr_win,
    input  logic [7:0] i_win,
    input  logic       i_win_v,
    output logic [7:0] o_win,
    output logic       o_win_v,
    input  logic       i_active,
    output logic       o_hit
);

    logic [7:0] r_pat;
    logic       r_wild;
    logic [7:0] r_win;
    logic       r_win_v;

    always_ff @(posedge i_clk) begin
        if (i_shift_pat) begin
            r_pat  <= i_pat;
            r_wild <= i_wild;
        end
        if (i_shift_win) begin
            r_win <= i_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_v <= 1'b0;
        end else if (i_clr_win) begin
            r_win_v <= 1'b0;
        end else if (i_shift_win) begin
            r_win_v <= i_win_v;
        end
    end

    assign o_pat   = r_pat;
    assign o_wild  = r_wild;
    assign o_win   = r_win;
    assign o_win_v = r_win_v;
    assign o_hit   = !i_active || (i_win_v && (r_wild || r_pat == i_win));

endmodule
